// File: src/dds_pkg.sv
// Shared constants, types and the sine table of the waveform generator.
package dds_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	localparam int ROM_QUARTER = 1 << SINE_TABLE_BITS;
	localparam int ROM_ENTRIES = ROM_QUARTER + 1;
	localparam int ROM_ADDR_W  = SINE_TABLE_BITS + 1;
	localparam int ROM_DATA_W  = SAMPLE_BITS - 1;

	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int IN_TDATA_W  = 8;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;
	localparam int INC_W       = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_INCREMENT = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM        = CFG_INDEX_W'(1);

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_SAWTOOTH = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} waveform_t;

	// Fields carried from the phase stage to the output register.
	typedef struct packed {
		logic                   is_sine;
		logic                   negate;
		logic [SAMPLE_BITS-1:0] direct;
	} stage1_t;

	typedef logic [0:ROM_ENTRIES-1][ROM_DATA_W-1:0] sine_rom_t;

	localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

	// Restoring long division, used only while the table is built.
	function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Quarter-wave sine table, Q31 Taylor series, evaluated at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t         rom;
		logic [63:0]       x;
		logic [63:0]       x2;
		logic [63:0]       term;
		logic [63:0]       n;
		logic [63:0]       v;
		logic signed [63:0] sum;
		logic              sub;
		for (int k = 0; k < ROM_ENTRIES; k++) begin
			x = (HALF_PI_Q31 * 64'(k) + 64'(ROM_QUARTER >> 1)) >> SINE_TABLE_BITS;
			x2 = (x * x + (64'd1 << 30)) >> 31;
			term = x;
			sum = $signed(x);
			n = 64'd1;
			sub = 1'b1;
			while (term != 64'd0 && n < 64'd40) begin
				term = div_u64((term * x2) >> 31, (n + 64'd1) * (n + 64'd2));
				if (sub) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
				sub = !sub;
				n = n + 64'd2;
			end
			if (sum < 0) begin
				sum = 64'sd0;
			end
			v = ($unsigned(sum) * (64'd1 << (SAMPLE_BITS - 1)) + (64'd1 << 30)) >> 31;
			if (v > ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)) begin
				v = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
			end
			rom[k] = v[ROM_DATA_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: src/dds_waveform_generator.sv
// Top level of the phase-accumulator waveform generator.
// Each accepted input transaction yields one signed Q1.15 sample taken from the
// current phase (cleared first when restart is set); the tuning word is then
// added to the 32-bit phase, which wraps. The waveform register picks sine
// (quarter-wave table), square, rising sawtooth or triangle. One transaction is
// accepted per clock unless the output stalls. The registered sine table read
// and the phase-derived fields register together in the first stage, and the
// output register that presents the sample follows.
// Configuration writes are always ready and take effect for following inputs.
module dds_waveform_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dds_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dds_pkg::TDATA_W-1:0]     m_tdata,   // [15:0] sample
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dds_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int S = dds_pkg::SAMPLE_BITS;

	logic [dds_pkg::INC_W-1:0]      phase_increment_q;
	dds_pkg::waveform_t             waveform_q;
	logic                           accept;
	logic                           advance;
	logic                           out_en;
	logic                           valid_s1;
	dds_pkg::stage1_t               stage_s1;
	logic [dds_pkg::ROM_ADDR_W-1:0] rom_addr;
	logic [dds_pkg::ROM_DATA_W-1:0] rom_data_s1;
	logic [S-1:0]                   sine_val;
	logic [S-1:0]                   sample;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_increment_q <= '0;
			waveform_q <= dds_pkg::WAVE_SINE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dds_pkg::CFG_PHASE_INCREMENT: begin
					phase_increment_q <= cfg_data[dds_pkg::INC_W-1:0];
				end
				dds_pkg::CFG_WAVEFORM: begin
					waveform_q <= dds_pkg::waveform_t'(cfg_data[1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Stall the pipeline only where the output register is full and not drained.
	assign out_en = !m_tvalid || m_tready;
	assign advance = !valid_s1 || out_en;
	assign s_tready = advance;
	assign accept = s_tvalid && s_tready;

	dds_phase_stage u_phase (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.advance         (advance),
		.restart         (s_tdata[0]),
		.phase_increment (phase_increment_q),
		.waveform        (waveform_q),
		.rom_addr        (rom_addr),
		.valid_s1        (valid_s1),
		.stage_s1        (stage_s1)
	);

	dds_sine_rom u_rom (
		.clk     (clk),
		.en      (advance),
		.addr    (rom_addr),
		.data_s1 (rom_data_s1)
	);

	assign sine_val = stage_s1.negate ? -{1'b0, rom_data_s1} : {1'b0, rom_data_s1};
	assign sample = stage_s1.is_sine ? sine_val : stage_s1.direct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_en) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			m_tdata <= dds_pkg::TDATA_W'(sample);
		end
	end

endmodule

// File: src/dds_sine_rom.sv
// Quarter-wave sine table with registered read.
module dds_sine_rom (
	input  logic                           clk,
	input  logic                           en,
	input  logic [dds_pkg::ROM_ADDR_W-1:0] addr,
	output logic [dds_pkg::ROM_DATA_W-1:0] data_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= dds_pkg::SINE_ROM[addr];
		end
	end

endmodule

// File: src/dds_phase_stage.sv
// Phase accumulator and first pipeline stage: ROM address and direct waveforms.
module dds_phase_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           advance,
	input  logic                           restart,
	input  logic [dds_pkg::INC_W-1:0]      phase_increment,
	input  dds_pkg::waveform_t             waveform,
	output logic [dds_pkg::ROM_ADDR_W-1:0] rom_addr,
	output logic                           valid_s1,
	output dds_pkg::stage1_t               stage_s1
);

	localparam int P = dds_pkg::PHASE_BITS;
	localparam int S = dds_pkg::SAMPLE_BITS;
	localparam int T = dds_pkg::SINE_TABLE_BITS;

	localparam logic signed [S+1:0] HALF   = (S+2)'(1) <<< (S - 1);
	localparam logic signed [S+1:0] THREE_HALF = (S+2)'(3) <<< (S - 1);
	localparam logic signed [S+1:0] SAT_MAX = HALF - (S+2)'(1);

	logic [P-1:0]     phase_q;
	logic [P-1:0]     phase;
	logic [P-1:0]     inc;
	logic [P+S:0]     phase_ext;
	logic [S-1:0]     saw_top;
	logic [S:0]       tri_v;
	logic signed [S+1:0] tri_r;
	logic [1:0]       quad;
	logic [T-1:0]     idx;
	dds_pkg::stage1_t stage;

	assign inc = P'(phase_increment);
	assign phase = restart ? '0 : phase_q;

	// Phase scaled up so that the top bits give floor(p * 2^n / 2^P).
	assign phase_ext = {phase, (S+1)'(0)};
	assign saw_top = phase_ext[P+S:P+1];
	assign tri_v = phase_ext[P+S:P];

	assign quad = phase[P-1:P-2];
	assign idx = phase[P-3:P-2-T];

	always_comb begin
		if (quad[0]) begin
			rom_addr = dds_pkg::ROM_ADDR_W'(dds_pkg::ROM_QUARTER) - {1'b0, idx};
		end else begin
			rom_addr = {1'b0, idx};
		end
	end

	always_comb begin
		if (!phase[P-1]) begin
			tri_r = $signed({1'b0, tri_v}) - HALF;
		end else begin
			tri_r = THREE_HALF - $signed({1'b0, tri_v});
		end
	end

	always_comb begin
		stage.is_sine = 1'b0;
		stage.negate = quad[1];
		stage.direct = '0;
		unique case (waveform)
			dds_pkg::WAVE_SINE: begin
				stage.is_sine = 1'b1;
			end
			dds_pkg::WAVE_SQUARE: begin
				stage.direct = phase[P-1] ? {1'b1, (S-1)'(0)} : {1'b0, {(S-1){1'b1}}};
			end
			dds_pkg::WAVE_SAWTOOTH: begin
				stage.direct = {~saw_top[S-1], saw_top[S-2:0]};
			end
			dds_pkg::WAVE_TRIANGLE: begin
				// saturate only at exactly half a cycle
				stage.direct = (tri_r > SAT_MAX) ? SAT_MAX[S-1:0] : tri_r[S-1:0];
			end
			default: begin
				stage.is_sine = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase + inc;
			end
			if (advance) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stage_s1 <= stage;
		end
	end

endmodule
